// ----- src/mptd_pkg.sv -----
`timescale 1ns / 1ps

package mptd_pkg;

    // Field widths
    localparam int PIN_W      = 5;
    localparam int ELAPSED_W  = 10;
    localparam int TIME_W     = 11;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Default number of handled pins
    localparam int DEF_PIN_COUNT = 32;

    // Debounce limits and accumulator ceiling
    localparam logic [TIME_W-1:0] LIMIT_FAST = TIME_W'(100);
    localparam logic [TIME_W-1:0] LIMIT_SLOW = TIME_W'(250);
    localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

    // Event kinds
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOGGLE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERTED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK     = 3'd4;

    // Per-pin state entry
    typedef struct packed {
        logic [TIME_W-1:0] high_time;
        logic [TIME_W-1:0] low_time;
        logic              level;
    } t_pin_state;

endpackage

// ----- src/mptd_state.sv -----
`timescale 1ns / 1ps

module mptd_state #(
    parameter int PIN_COUNT = mptd_pkg::DEF_PIN_COUNT,
    localparam int AW = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  mptd_pkg::t_pin_state i_wr_data,
    output mptd_pkg::t_pin_state o_rd_data
);
    import mptd_pkg::*;

    t_pin_state       mem [PIN_COUNT];
    logic [PIN_COUNT-1:0] r_vld;
    t_pin_state       r_rd_data;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_addr;
    logic             r_wb_valid;
    logic [AW-1:0]    r_wb_addr;
    t_pin_state       r_wb_data;

    // Write back and register the read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // Track written entries and the last write for forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_rd_vld   <= 1'b0;
            r_wb_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
                r_wb_valid       <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_wb_addr <= i_wr_addr;
            r_wb_data <= i_wr_data;
        end
    end

    // Forward the last write, treat unwritten entries as cleared
    always_comb begin
        if (r_wb_valid && (r_wb_addr == r_rd_addr)) begin
            o_rd_data = r_wb_data;
        end else if (r_rd_vld) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = '0;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |=> r_wb_valid && (r_wb_addr == $past(i_wr_addr)))
        else $error("forwarding register missed a write");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |=> r_vld[$past(i_wr_addr)])
        else $error("written entry not marked valid");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd_en && i_wr_en && (i_rd_addr == i_wr_addr)) |=> (o_rd_data == $past(i_wr_data)))
        else $error("read after same-entry write returned stale state");

endmodule

// ----- src/multi_pin_time_debouncer_unit.sv -----
`timescale 1ns / 1ps

// Multi-pin time-based switch debouncer.
// Input channel (i_in_valid / o_in_ready): one sample per request, holding the
// pin index, its raw level and the milliseconds since that pin's last sample.
// Output channel (o_out_valid / i_out_ready): one result per request, giving the
// event kind (none, set level, toggle), the pin, the debounced level and the
// child-lock suppressed flag.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (enabled, inverted, toggle pins, fast debounce, child lock); write only
// while no request is in flight.
// o_out_valid rises once a request has passed the update stage and the output
// register; throughput is one request per cycle unless the receiver stalls.
// Per-pin state sits in a memory with a registered read; the read is issued at
// accept and the update is written back as the request leaves the update
// stage, with the last write forwarded so the same pin can follow back to back.
// Reset clears all configuration, the pipeline and the per-pin valid flags, so
// every pin starts at zero time and level low; no clearing pass is needed.
// When the receiver stalls, the output register holds its result and the
// update stage holds its request; input stays ready while one stage can move.
module multi_pin_time_debouncer_unit #(
    parameter int PIN_COUNT = mptd_pkg::DEF_PIN_COUNT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mptd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mptd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [mptd_pkg::PIN_W-1:0]       i_pin_index,
    input  logic                             i_raw_level,
    input  logic [mptd_pkg::ELAPSED_W-1:0]   i_elapsed_ms,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [mptd_pkg::KIND_W-1:0]      o_event_kind,
    output logic [mptd_pkg::PIN_W-1:0]       o_event_pin,
    output logic                             o_new_level,
    output logic                             o_suppressed
);
    import mptd_pkg::*;

    localparam int AW     = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
    localparam int PIDX_W = (AW > PIN_W) ? AW : PIN_W;

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_enabled;
    logic [CFG_DATA_W-1:0] r_inverted;
    logic [CFG_DATA_W-1:0] r_toggle;
    logic                  r_fast;
    logic                  r_lock;

    // Update stage
    logic                  r_s1_valid;
    logic [PIN_W-1:0]      r_s1_pin;
    logic                  r_s1_level;
    logic [ELAPSED_W-1:0]  r_s1_elapsed;

    // Output register
    logic                  r_out_valid;
    logic [KIND_W-1:0]     r_out_kind;
    logic [PIN_W-1:0]      r_out_pin;
    logic                  r_out_level;
    logic                  r_out_supp;

    logic                  in_acc;
    logic                  s1_adv;
    logic [PIDX_W-1:0]     in_pin_ext;
    logic [PIDX_W-1:0]     s1_pin_ext;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         s1_addr;
    logic                  in_range;
    logic                  pin_on;
    logic                  lvl;
    logic [TIME_W-1:0]     limit;
    logic [TIME_W-1:0]     sel_time;
    logic [TIME_W:0]       sum;
    logic [TIME_W-1:0]     sat_time;
    logic [TIME_W-1:0]     next_time;
    logic                  over;
    logic                  change;
    logic                  wr_en;
    t_pin_state            cur;
    t_pin_state            nxt;
    logic [KIND_W-1:0]     n_kind;
    logic                  n_level;
    logic                  n_supp;

    // Handshake
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    assign in_pin_ext = PIDX_W'(i_pin_index);
    assign s1_pin_ext = PIDX_W'(r_s1_pin);
    assign rd_addr    = in_pin_ext[AW-1:0];
    assign s1_addr    = s1_pin_ext[AW-1:0];

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= '0;
            r_inverted <= '0;
            r_toggle   <= '0;
            r_fast     <= 1'b0;
            r_lock     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLED:  r_enabled  <= i_cfg_data;
                CFG_INVERTED: r_inverted <= i_cfg_data;
                CFG_TOGGLE:   r_toggle   <= i_cfg_data;
                CFG_FAST:     r_fast     <= i_cfg_data[0];
                CFG_LOCK:     r_lock     <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Per-pin state memory
    mptd_state #(
        .PIN_COUNT (PIN_COUNT)
    ) u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (s1_addr),
        .i_wr_data (nxt),
        .o_rd_data (cur)
    );

    // Advance the update stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pin     <= i_pin_index;
            r_s1_level   <= i_raw_level;
            r_s1_elapsed <= i_elapsed_ms;
        end
    end

    // Debounce update
    always_comb begin
        in_range  = {1'b0, s1_pin_ext} < (PIDX_W + 1)'(PIN_COUNT);
        pin_on    = in_range && r_enabled[r_s1_pin];
        lvl       = r_s1_level ^ r_inverted[r_s1_pin];
        limit     = r_fast ? LIMIT_FAST : LIMIT_SLOW;
        sel_time  = lvl ? cur.high_time : cur.low_time;
        over      = sel_time > limit;
        sum       = {1'b0, sel_time} + (TIME_W + 1)'(r_s1_elapsed);
        sat_time  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        next_time = over ? sel_time : sat_time;
        change    = over && (cur.level != lvl);

        nxt.high_time = lvl ? next_time : '0;
        nxt.low_time  = lvl ? '0 : next_time;
        nxt.level     = over ? lvl : cur.level;

        wr_en = s1_adv && pin_on;

        if (pin_on) begin
            n_level = nxt.level;
            if (change) begin
                n_kind = r_toggle[r_s1_pin] ? KIND_TOGGLE : KIND_SET;
                n_supp = r_toggle[r_s1_pin] && r_lock;
            end else begin
                n_kind = KIND_NONE;
                n_supp = 1'b0;
            end
        end else begin
            n_kind  = KIND_NONE;
            n_supp  = 1'b0;
            n_level = in_range && cur.level;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_kind  <= n_kind;
            r_out_pin   <= r_s1_pin;
            r_out_level <= n_level;
            r_out_supp  <= n_supp;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_out_kind;
    assign o_event_pin  = r_out_pin;
    assign o_new_level  = r_out_level;
    assign o_suppressed = r_out_supp;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_suppressed) |-> (o_event_kind == KIND_TOGGLE))
        else $error("suppressed flag on a non-toggle event");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_s1_valid) |-> s1_adv)
        else $error("request accepted over a stalled update stage");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_s1_valid && in_range))
        else $error("state written without a valid in-range request");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_kind <= KIND_TOGGLE))
        else $error("reserved event kind");

endmodule

// ----- bench/multi_pin_time_debouncer_unit_tb.sv -----
`timescale 1ns / 1ps

module multi_pin_time_debouncer_unit_tb;
    import mptd_pkg::*;

    localparam int NUM_PINS      = DEF_PIN_COUNT;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_SLACK   = 4;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_SAMPLES = 135;

    // Register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Pin roles used by the directed tests
    localparam logic [CFG_DATA_W-1:0] DIR_INVERTED = 32'h8000_0000;
    localparam logic [CFG_DATA_W-1:0] DIR_TOGGLE   = 32'h0000_0002;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PIN_W-1:0]  pin;
        logic              level;
        logic              supp;
    } t_debounce_event;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [PIN_W-1:0]      i_pin_index = '0;
    logic                  i_raw_level = 1'b0;
    logic [ELAPSED_W-1:0]  i_elapsed_ms = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [KIND_W-1:0]     o_event_kind;
    logic [PIN_W-1:0]      o_event_pin;
    logic                  o_new_level;
    logic                  o_suppressed;

    // Predictor copy of the configuration and per-pin state
    logic [CFG_DATA_W-1:0] cfg_enabled = '0;
    logic [CFG_DATA_W-1:0] cfg_inverted = '0;
    logic [CFG_DATA_W-1:0] cfg_toggle = '0;
    logic                  cfg_fast = 1'b0;
    logic                  cfg_lock = 1'b0;
    logic [TIME_W-1:0]     pin_high [NUM_PINS] = '{default: '0};
    logic [TIME_W-1:0]     pin_low [NUM_PINS] = '{default: '0};
    logic                  pin_level [NUM_PINS] = '{default: 1'b0};

    t_debounce_event pending_events[$];
    int              mismatch_count = 0;
    int              quiet_cycles = 0;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;

    multi_pin_time_debouncer_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pin_index  (i_pin_index),
        .i_raw_level  (i_raw_level),
        .i_elapsed_ms (i_elapsed_ms),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_kind (o_event_kind),
        .o_event_pin  (o_event_pin),
        .o_new_level  (o_new_level),
        .o_suppressed (o_suppressed)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Apply one sample to the predicted pin state and return the event it causes
    function automatic t_debounce_event debounce_sample(input logic [PIN_W-1:0] pin,
            input logic raw, input logic [ELAPSED_W-1:0] elapsed_ms);
        t_debounce_event   ev;
        logic [TIME_W-1:0] limit;
        logic [TIME_W-1:0] grow;
        logic [TIME_W:0]   sum;
        logic              lvl;
        ev.kind  = KIND_NONE;
        ev.pin   = pin;
        ev.level = 1'b0;
        ev.supp  = 1'b0;
        if (int'(pin) >= NUM_PINS)
            return ev;
        limit    = cfg_fast ? LIMIT_FAST : LIMIT_SLOW;
        ev.level = pin_level[pin];
        if (cfg_enabled[pin]) begin
            lvl  = raw ^ cfg_inverted[pin];
            grow = lvl ? pin_high[pin] : pin_low[pin];
            // accept the level once its time is past the limit, else keep counting
            if (grow > limit) begin
                if (ev.level != lvl) begin
                    ev.level = lvl;
                    ev.kind  = KIND_SET;
                end
            end else begin
                sum  = {1'b0, grow} + (TIME_W + 1)'(elapsed_ms);
                grow = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
            end
            // the opposite accumulator restarts
            if (lvl) begin
                pin_high[pin] = grow;
                pin_low[pin]  = '0;
            end else begin
                pin_low[pin]  = grow;
                pin_high[pin] = '0;
            end
            pin_level[pin] = ev.level;
            if (ev.kind != KIND_NONE && cfg_toggle[pin]) begin
                ev.kind = KIND_TOGGLE;
                ev.supp = cfg_lock;
            end
        end
        return ev;
    endfunction

    // Offer one sample, with random idle cycles first; valid stays high on return
    task automatic send_sample(input logic [PIN_W-1:0] pin, input logic raw,
            input logic [ELAPSED_W-1:0] ms);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_pin_index  <= pin;
        i_raw_level  <= raw;
        i_elapsed_ms <= ms;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        pending_events.push_back(debounce_sample(pin, raw, ms));
    endtask

    // Hold the sender until every expected result is back and the pipe is empty
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    // Drive one register write; the enable stays high until cfg_close
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
            input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_ENABLED:  cfg_enabled  = data;
            CFG_INVERTED: cfg_inverted = data;
            CFG_TOGGLE:   cfg_toggle   = data;
            CFG_FAST:     cfg_fast     = data[0];
            CFG_LOCK:     cfg_lock     = data[0];
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] en,
            input logic [CFG_DATA_W-1:0] inv, input logic [CFG_DATA_W-1:0] tog,
            input logic fast, input logic lock);
        wait_for_drain();
        write_reg(CFG_ENABLED, en);
        write_reg(CFG_INVERTED, inv);
        write_reg(CFG_TOGGLE, tog);
        write_reg(CFG_FAST, {{(CFG_DATA_W-1){1'b0}}, fast});
        write_reg(CFG_LOCK, {{(CFG_DATA_W-1){1'b0}}, lock});
        cfg_close();
    endtask

    // Everything is disabled out of reset: no events, level low
    task automatic test_disabled_after_reset();
        send_sample(5'd0, 1'b1, 10'd1023);
        send_sample(5'd31, 1'b0, 10'd0);
        send_sample(5'd31, 1'b1, 10'd1023);
    endtask

    // Normal pin: set high, then low with the count sitting exactly on the limit
    task automatic test_set_level();
        apply_config('1, DIR_INVERTED, DIR_TOGGLE, 1'b0, 1'b0);
        send_sample(5'd0, 1'b1, 10'd1023);
        send_sample(5'd0, 1'b1, 10'd0);
        send_sample(5'd0, 1'b0, 10'd250);
        send_sample(5'd0, 1'b0, 10'd0);
        send_sample(5'd0, 1'b0, 10'd1);
        send_sample(5'd0, 1'b0, 10'd0);
    endtask

    // Active-low pin: a low electrical level debounces to logical high
    task automatic test_inverted_pin();
        send_sample(5'd31, 1'b0, 10'd1023);
        send_sample(5'd31, 1'b0, 10'd0);
    endtask

    // Toggle pin with and without the child lock
    task automatic test_toggle_lock();
        send_sample(5'd1, 1'b1, 10'd300);
        send_sample(5'd1, 1'b1, 10'd0);
        apply_config('1, DIR_INVERTED, DIR_TOGGLE, 1'b0, 1'b1);
        send_sample(5'd1, 1'b0, 10'd300);
        send_sample(5'd1, 1'b0, 10'd0);
    endtask

    // Switch to the fast limit with time already counted under the slow one
    task automatic test_limit_change();
        send_sample(5'd2, 1'b1, 10'd150);
        apply_config('1, DIR_INVERTED, DIR_TOGGLE, 1'b1, 1'b0);
        send_sample(5'd2, 1'b1, 10'd0);
    endtask

    // A bounce clears the count, which then has to build up again
    task automatic test_bounce_restart();
        send_sample(5'd3, 1'b1, 10'd200);
        send_sample(5'd3, 1'b0, 10'd5);
        send_sample(5'd3, 1'b1, 10'd90);
        send_sample(5'd3, 1'b1, 10'd20);
        send_sample(5'd3, 1'b1, 10'd0);
    endtask

    // A disabled pin reports its stored level and does not move
    task automatic test_disabled_hold();
        apply_config(32'h7FFF_FFFF, DIR_INVERTED, DIR_TOGGLE, 1'b1, 1'b0);
        send_sample(5'd31, 1'b0, 10'd1023);
    endtask

    // Writes to undecoded indexes leave the configuration alone
    task automatic test_spare_index();
        wait_for_drain();
        write_reg(CFG_SPARE_LO, '0);
        write_reg(CFG_SPARE_HI, '0);
        cfg_close();
        send_sample(5'd2, 1'b0, 10'd1023);
        send_sample(5'd2, 1'b0, 10'd0);
    endtask

    // Mostly steady levels on a few busy pins, with bounces and scattered noise
    task automatic test_random_traffic();
        logic             drive_level [NUM_PINS];
        logic [PIN_W-1:0] hot [4];
        logic [PIN_W-1:0] pin;
        logic             raw;
        logic [ELAPSED_W-1:0] ms;
        int               counted;
        int               roll;
        foreach (drive_level[i])
            drive_level[i] = 1'b0;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: apply_config('1, '1, '1, 1'b1, 1'b1);
                1: apply_config('1, '0, '0, 1'b0, 1'b0);
                default: apply_config($urandom | $urandom, $urandom, $urandom,
                                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            foreach (hot[i])
                hot[i] = PIN_W'($urandom_range(0, NUM_PINS - 1));
            counted = 0;
            while (counted < PHASE_SAMPLES) begin
                pin = ($urandom_range(0, 99) < 75) ? hot[2'($urandom_range(0, 3))]
                                                  : PIN_W'($urandom_range(0, NUM_PINS - 1));
                if ($urandom_range(0, 9) == 0)
                    drive_level[pin] = ~drive_level[pin];
                raw = drive_level[pin];
                if ($urandom_range(0, 99) < 15)
                    raw = ~raw;
                roll = $urandom_range(0, 99);
                if (roll < 10)
                    ms = '0;
                else if (roll < 15)
                    ms = '1;
                else if (roll < 30)
                    ms = ELAPSED_W'($urandom_range(0, 1023));
                else
                    ms = ELAPSED_W'($urandom_range(1, 120));
                counted++;
                send_sample(pin, raw, ms);
                // now and then hold the sender until the block is empty
                if ($urandom_range(0, 199) == 0)
                    wait_for_drain();
            end
        end
    endtask

    // Receiver backpressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each result against the oldest predicted event
    always @(posedge i_clk) begin
        t_debounce_event want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_events.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result pin %0d kind %0d", $time,
                         o_event_pin, o_event_kind);
            end else begin
                want = pending_events.pop_front();
                if (o_event_kind !== want.kind) begin
                    mismatch_count++;
                    $display("%0t: event_kind expected %0d actual %0d", $time,
                             want.kind, o_event_kind);
                end
                if (o_event_pin !== want.pin) begin
                    mismatch_count++;
                    $display("%0t: event_pin expected %0d actual %0d", $time,
                             want.pin, o_event_pin);
                end
                if (o_new_level !== want.level) begin
                    mismatch_count++;
                    $display("%0t: new_level (pin %0d) expected %0d actual %0d", $time,
                             want.pin, want.level, o_new_level);
                end
                if (o_suppressed !== want.supp) begin
                    mismatch_count++;
                    $display("%0t: suppressed (pin %0d) expected %0d actual %0d", $time,
                             want.pin, want.supp, o_suppressed);
                end
            end
        end
    end

    // Abort when no request moves on either channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog, no request moved for %0d cycles, %0d pending",
                     $time, quiet_cycles, pending_events.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_disabled_after_reset();
        test_set_level();
        test_inverted_pin();
        test_toggle_lock();
        test_limit_change();
        test_bounce_restart();
        test_disabled_hold();
        test_spare_index();
        test_random_traffic();
        wait_for_drain();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
